FILE: rtl/core/drf_pkg.sv
// shared types, codes and defaults for the detection region filter
`default_nettype none
package drf_pkg;

	localparam int DEF_MAX_VERTICES = 16;
	localparam int DEF_MAX_ZONES    = 8;
	localparam int DEF_NUM_LABELS   = 256;

	localparam logic [6:0] RST_CONF_THR = 7'd50;
	localparam logic [9:0] RST_MIN_W    = 10'd0;
	localparam logic [9:0] RST_MIN_H    = 10'd0;
	localparam logic [9:0] RST_AOI_LO   = 10'd100;
	localparam logic [9:0] RST_AOI_HI   = 10'd900;

	typedef enum logic [1:0] {
		KIND_DET   = 2'd0,
		KIND_AREA  = 2'd1,
		KIND_EXCL  = 2'd2,
		KIND_LABEL = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		RSN_NONE  = 3'd0,
		RSN_CONF  = 3'd1,
		RSN_SIZE  = 3'd2,
		RSN_AREA  = 3'd3,
		RSN_EXCL  = 3'd4,
		RSN_LABEL = 3'd5
	} reason_t;

	typedef enum logic [2:0] {
		CFG_CONF_THR = 3'd0,
		CFG_MIN_W    = 3'd1,
		CFG_MIN_H    = 3'd2,
		CFG_AOI_L    = 3'd3,
		CFG_AOI_T    = 3'd4,
		CFG_AOI_R    = 3'd5,
		CFG_AOI_B    = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ZSEL,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [9:0] y;
		logic [9:0] x;
	} vertex_t;

	typedef struct packed {
		logic       area;
		logic       excl;
		logic [2:0] zone;
		logic [3:0] vidx;
		logic       flag;
		logic       closes;
		vertex_t    vtx;
	} vtx_load_t;

endpackage
`default_nettype wire

FILE: rtl/core/drf_vtx_store.sv
// vertex memory for the area polygon and the exclude zones, with counts and zone flags
`default_nettype none
module drf_vtx_store #(
	parameter int MAX_VERTICES = drf_pkg::DEF_MAX_VERTICES,
	parameter int MAX_ZONES    = drf_pkg::DEF_MAX_ZONES
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  drf_pkg::vtx_load_t                     load,
	input  logic                                   rd_en,
	input  logic [$clog2(MAX_ZONES+1)-1:0]         rd_poly,
	input  logic [$clog2(MAX_VERTICES)-1:0]        rd_idx,
	output drf_pkg::vertex_t                       rd_data,
	output logic [$clog2(MAX_VERTICES+1)-1:0]      area_cnt,
	input  logic [((MAX_ZONES>1)?$clog2(MAX_ZONES):1)-1:0] zsel,
	output logic [$clog2(MAX_VERTICES+1)-1:0]      zone_cnt,
	output logic                                   zone_act
);
	import drf_pkg::*;

	localparam int DEPTH = (MAX_ZONES + 1) * MAX_VERTICES;
	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int ZW    = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;

	vertex_t          mem [DEPTH];
	vertex_t          rdata_q;
	logic [CNT_W-1:0] area_cnt_q;
	logic [CNT_W-1:0] zcnt_q [MAX_ZONES];
	logic             zact_q [MAX_ZONES];

	logic             vi_ok, z_ok, wr_en;
	logic [AW-1:0]    waddr, raddr;
	logic [CNT_W-1:0] new_cnt;
	logic [ZW-1:0]    wzone;

	assign vi_ok   = 32'(load.vidx) < MAX_VERTICES;
	assign z_ok    = 32'(load.zone) < MAX_ZONES;
	assign wr_en   = (load.area && vi_ok) || (load.excl && vi_ok && z_ok);
	assign new_cnt = CNT_W'(32'(load.vidx) + 1);
	assign wzone   = ZW'(load.zone);
	assign waddr   = load.area ? AW'(load.vidx)
	                           : AW'((32'(load.zone) + 1) * MAX_VERTICES + 32'(load.vidx));
	assign raddr   = AW'(32'(rd_poly) * MAX_VERTICES + 32'(rd_idx));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= load.vtx;
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_cnt_q <= '0;
			for (int z = 0; z < MAX_ZONES; z++) begin
				zcnt_q[z] <= '0;
				zact_q[z] <= 1'b0;
			end
		end else begin
			if (load.area && vi_ok && load.closes) begin
				area_cnt_q <= new_cnt;
			end
			if (load.excl && vi_ok && z_ok) begin
				zact_q[wzone] <= load.flag;
				if (load.closes) begin
					zcnt_q[wzone] <= new_cnt;
				end
			end
		end
	end

	assign rd_data  = rdata_q;
	assign area_cnt = area_cnt_q;
	assign zone_cnt = zcnt_q[zsel];
	assign zone_act = zact_q[zsel];

endmodule
`default_nettype wire

FILE: rtl/core/drf_label_store.sv
// label ignore flags in a memory, cleared by a sweep after reset
`default_nettype none
module drf_label_store #(
	parameter int NUM_LABELS = drf_pkg::DEF_NUM_LABELS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [$clog2(NUM_LABELS)-1:0] waddr,
	input  logic                          wdata,
	input  logic [$clog2(NUM_LABELS)-1:0] raddr,
	output logic                          rdata,
	output logic                          busy
);
	import drf_pkg::*;

	localparam int LAW = $clog2(NUM_LABELS);

	logic           mem [NUM_LABELS];
	logic           rdata_q;
	logic           busy_q;
	logic [LAW-1:0] clr_q;

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= 1'b0;
		end else if (wr_en) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			if (32'(clr_q) == NUM_LABELS - 1) begin
				busy_q <= 1'b0;
			end else begin
				clr_q <= clr_q + LAW'(1);
			end
		end
	end

	assign rdata = rdata_q;
	assign busy  = busy_q;

endmodule
`default_nettype wire

FILE: rtl/core/drf_edge_test.sv
// pipelined even-odd crossing test, one polygon edge per vertex word
`default_nettype none
module drf_edge_test (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clear,
	input  logic             vin_vld,
	input  drf_pkg::vertex_t vin,
	input  logic [10:0]      px,
	input  logic [10:0]      py,
	output logic             in_poly
);
	import drf_pkg::*;

	vertex_t            prev_q;
	logic               have_q;
	logic               vld_s2, cond_s2, dypos_s2, parity_q;
	logic signed [25:0] lhs_s2, rhs_s2;

	logic signed [12:0] a, c, dy, b;
	logic               cond;

	// i is the incoming vertex, j the one before it
	always_comb begin
		dy   = $signed({3'b0, prev_q.y}) - $signed({3'b0, vin.y});
		a    = $signed({2'b0, px}) - $signed({3'b0, vin.x});
		b    = $signed({3'b0, prev_q.x}) - $signed({3'b0, vin.x});
		c    = $signed({2'b0, py}) - $signed({3'b0, vin.y});
		cond = ({1'b0, vin.y} > py) != ({1'b0, prev_q.y} > py);
	end

	always_ff @(posedge clk) begin
		if (vin_vld) begin
			prev_q   <= vin;
			cond_s2  <= cond;
			dypos_s2 <= dy > 0;
			lhs_s2   <= a * dy;
			rhs_s2   <= b * c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q   <= 1'b0;
			vld_s2   <= 1'b0;
			parity_q <= 1'b0;
		end else if (clear) begin
			have_q   <= 1'b0;
			vld_s2   <= 1'b0;
			parity_q <= 1'b0;
		end else begin
			if (vin_vld) begin
				have_q <= 1'b1;
			end
			vld_s2 <= vin_vld && have_q;
			if (vld_s2 && cond_s2 &&
			    (dypos_s2 ? (lhs_s2 < rhs_s2) : (lhs_s2 > rhs_s2))) begin
				parity_q <= !parity_q;
			end
		end
	end

	assign in_poly = parity_q;

endmodule
`default_nettype wire

FILE: rtl/core/detection_region_filter.sv
// top level of the detection region filter
`default_nettype none
// Filters detections in a 0..1000 normalized space. Each input word is one of
// four kinds (tuser): a detection, an area polygon vertex, an exclude zone
// vertex or a label ignore flag. Only detections give an output word, which
// carries the verdict, the reject reason and the computed center. Checks run
// in order: confidence, size, area of interest (polygon with 3 or more
// vertices, else the inclusive fallback box), active exclude zones, label.
// Polygon tests walk the vertex memory one vertex per cycle. A finished
// detection is held back while a previous result still waits. Load words
// go straight to the stores, and the block stays ready for the next word.
// The block works on one detection at a time and takes no input
// word while a detection is in progress; a finished result waits in the
// output register while the next word is taken. After reset the label flag
// memory is swept clear, during which tready stays low; configuration
// writes are taken at any time.
module detection_region_filter #(
	parameter int MAX_VERTICES = drf_pkg::DEF_MAX_VERTICES,
	parameter int MAX_ZONES    = drf_pkg::DEF_MAX_ZONES,
	parameter int NUM_LABELS   = drf_pkg::DEF_NUM_LABELS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// pos_x, pos_y, box_width, box_height, confidence, label_index,
	// zone_index, vertex_index, flag, zero pad
	input  logic [63:0] s_axis_tdata,
	// kind
	input  logic [1:0]  s_axis_tuser,
	// closes_polygon
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// accepted, reject_reason, center_x, center_y, zero pad
	output logic [31:0] m_axis_tdata,
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_index,
	input  logic [9:0]  cfg_data
);
	import drf_pkg::*;

	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int VI_W  = $clog2(MAX_VERTICES);
	localparam int PW    = $clog2(MAX_ZONES + 1);
	localparam int ZW    = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
	localparam int LAW   = $clog2(NUM_LABELS);

	// input word fields
	kind_t      kind;
	logic [9:0] pos_x, pos_y, box_width, box_height;
	logic [6:0] confidence;
	logic [7:0] label_index;
	logic [2:0] zone_index;
	logic [3:0] vertex_index;
	logic       flag, closes_polygon;

	assign kind           = kind_t'(s_axis_tuser);
	assign pos_x          = s_axis_tdata[9:0];
	assign pos_y          = s_axis_tdata[19:10];
	assign box_width      = s_axis_tdata[29:20];
	assign box_height     = s_axis_tdata[39:30];
	assign confidence     = s_axis_tdata[46:40];
	assign label_index    = s_axis_tdata[54:47];
	assign zone_index     = s_axis_tdata[57:55];
	assign vertex_index   = s_axis_tdata[61:58];
	assign flag           = s_axis_tdata[62];
	assign closes_polygon = s_axis_tlast;

	// configuration registers
	logic [6:0] conf_thr_q;
	logic [9:0] min_w_q, min_h_q, aoi_l_q, aoi_t_q, aoi_r_q, aoi_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conf_thr_q <= RST_CONF_THR;
			min_w_q    <= RST_MIN_W;
			min_h_q    <= RST_MIN_H;
			aoi_l_q    <= RST_AOI_LO;
			aoi_t_q    <= RST_AOI_LO;
			aoi_r_q    <= RST_AOI_HI;
			aoi_b_q    <= RST_AOI_HI;
		end else if (cfg_wen) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_CONF_THR: conf_thr_q <= cfg_data[6:0];
				CFG_MIN_W:    min_w_q    <= cfg_data;
				CFG_MIN_H:    min_h_q    <= cfg_data;
				CFG_AOI_L:    aoi_l_q    <= cfg_data;
				CFG_AOI_T:    aoi_t_q    <= cfg_data;
				CFG_AOI_R:    aoi_r_q    <= cfg_data;
				CFG_AOI_B:    aoi_b_q    <= cfg_data;
				default: ;  // unused index, write dropped
			endcase
		end
	end

	// sequencer state and registers
	state_t           state_q, state_d;
	reason_t          reason_q, reason_fin;
	logic [10:0]      cx_q, cy_q;
	logic             lbl_ok_q, ign_q;
	logic [PW-1:0]    zone_q, poly_q;
	logic [CNT_W-1:0] n_q, k_q;
	logic [1:0]       dr_q;
	logic             rd_vld_s1;
	logic             out_vld_q;
	logic [31:0]      out_data_q;

	// control decoded from the state
	logic             in_acc, det_acc;
	logic             rd_en, edge_clear, out_free, busy;
	logic [VI_W-1:0]  rd_idx;
	logic             box_in, area_poly, zone_go, zone_end, drain_end, in_poly;
	logic [CNT_W-1:0] area_cnt, zone_cnt;
	logic             zone_act, lbl_rdata;
	vertex_t          vtx_rdata;
	vtx_load_t        vload;

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign det_acc  = in_acc && (kind == KIND_DET);
	assign out_free = !out_vld_q || m_axis_tready;

	assign box_in    = (cx_q >= {1'b0, aoi_l_q}) && (cx_q <= {1'b0, aoi_r_q}) &&
	                   (cy_q >= {1'b0, aoi_t_q}) && (cy_q <= {1'b0, aoi_b_q});
	assign area_poly = area_cnt >= CNT_W'(3);
	assign zone_end  = zone_q == PW'(MAX_ZONES);
	assign zone_go   = zone_act && (zone_cnt >= CNT_W'(3));
	assign drain_end = dr_q == 2'd2;

	assign reason_fin = (reason_q == RSN_NONE && ign_q) ? RSN_LABEL : reason_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (det_acc) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (reason_q != RSN_NONE) state_d = ST_DONE;
				else if (area_poly)       state_d = ST_SCAN;
				else if (!box_in)         state_d = ST_DONE;
				else                      state_d = ST_ZSEL;
			end
			ST_ZSEL: begin
				if (zone_end)     state_d = ST_DONE;
				else if (zone_go) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (k_q == n_q) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (drain_end) begin
					if (poly_q == '0) state_d = in_poly ? ST_ZSEL : ST_DONE;
					else              state_d = in_poly ? ST_DONE : ST_ZSEL;
				end
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		rd_en         = 1'b0;
		edge_clear    = 1'b0;
		s_axis_tready = 1'b0;
		rd_idx        = (k_q == '0) ? VI_W'(n_q - CNT_W'(1)) : VI_W'(k_q - CNT_W'(1));
		unique case (state_q)
			ST_IDLE:  s_axis_tready = !busy;
			ST_CHECK: edge_clear    = (reason_q == RSN_NONE) && area_poly;
			ST_ZSEL:  edge_clear    = !zone_end && zone_go;
			ST_SCAN:  rd_en         = 1'b1;
			ST_DRAIN: ;
			ST_DONE:  ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			if (state_q == ST_DONE && out_free) out_vld_q <= 1'b1;
			else if (m_axis_tready)             out_vld_q <= 1'b0;
		end
	end

	// working registers of the detection in flight
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (det_acc) begin
					cx_q     <= {1'b0, pos_x} + {2'b0, box_width[9:1]};
					cy_q     <= {1'b0, pos_y} + {2'b0, box_height[9:1]};
					lbl_ok_q <= 32'(label_index) < NUM_LABELS;
					if (confidence < conf_thr_q)
						reason_q <= RSN_CONF;
					else if (box_width < min_w_q || box_height < min_h_q)
						reason_q <= RSN_SIZE;
					else
						reason_q <= RSN_NONE;
				end
			end
			ST_CHECK: begin
				// label flag was read at the accept edge
				ign_q <= lbl_rdata && lbl_ok_q;
				if (reason_q == RSN_NONE) begin
					if (area_poly) begin
						poly_q <= '0;
						n_q    <= area_cnt;
						k_q    <= '0;
					end else if (!box_in) begin
						reason_q <= RSN_AREA;
					end else begin
						zone_q <= '0;
					end
				end
			end
			ST_ZSEL: begin
				if (!zone_end) begin
					if (zone_go) begin
						poly_q <= zone_q + PW'(1);
						n_q    <= zone_cnt;
						k_q    <= '0;
					end else begin
						zone_q <= zone_q + PW'(1);
					end
				end
			end
			ST_SCAN: begin
				k_q  <= k_q + CNT_W'(1);
				dr_q <= '0;
			end
			ST_DRAIN: begin
				dr_q <= dr_q + 2'd1;
				if (drain_end) begin
					if (poly_q == '0) begin
						if (in_poly) zone_q   <= '0;
						else         reason_q <= RSN_AREA;
					end else begin
						if (in_poly) reason_q <= RSN_EXCL;
						else         zone_q   <= zone_q + PW'(1);
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_data_q <= {6'b0, cy_q, cx_q, reason_fin, reason_fin == RSN_NONE};
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

	// vertex loads go straight to the store on accept
	assign vload.area   = in_acc && (kind == KIND_AREA);
	assign vload.excl   = in_acc && (kind == KIND_EXCL);
	assign vload.zone   = zone_index;
	assign vload.vidx   = vertex_index;
	assign vload.flag   = flag;
	assign vload.closes = closes_polygon;
	assign vload.vtx    = '{y: pos_y, x: pos_x};

	drf_vtx_store #(
		.MAX_VERTICES(MAX_VERTICES),
		.MAX_ZONES   (MAX_ZONES)
	) u_vtx (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (vload),
		.rd_en   (rd_en),
		.rd_poly (poly_q),
		.rd_idx  (rd_idx),
		.rd_data (vtx_rdata),
		.area_cnt(area_cnt),
		.zsel    (ZW'(zone_q)),
		.zone_cnt(zone_cnt),
		.zone_act(zone_act)
	);

	drf_label_store #(
		.NUM_LABELS(NUM_LABELS)
	) u_lbl (
		.clk   (clk),
		.arst_n(arst_n),
		.wr_en (in_acc && (kind == KIND_LABEL) && (32'(label_index) < NUM_LABELS)),
		.waddr (LAW'(label_index)),
		.wdata (flag),
		.raddr (LAW'(label_index)),
		.rdata (lbl_rdata),
		.busy  (busy)
	);

	// each vertex word arrives in the cycle after its read
	drf_edge_test u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (edge_clear),
		.vin_vld(rd_vld_s1),
		.vin    (vtx_rdata),
		.px     (cx_q),
		.py     (cy_q),
		.in_poly(in_poly)
	);

endmodule
`default_nettype wire

FILE: rtl/core/drf_checker.sv
// port level checks for the detection region filter and their binding
`default_nettype none
module drf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [1:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);
	import drf_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// verdict agrees with the reason code
	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[3:1] == RSN_NONE)))
		else $error("accepted bit disagrees with reason");

	a_reason: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[3:1] <= RSN_LABEL))
		else $error("reason code out of range");

	// a detection keeps the input closed while it is worked on
	a_det_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_DET) |=> !s_axis_tready)
		else $error("input open during detection");

endmodule

bind detection_region_filter drf_checker u_drf_checker (.*);
`default_nettype wire

FILE: tb/tb.sv
// self-checking testbench for the detection region filter
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import drf_pkg::*;

	localparam int NV = DEF_MAX_VERTICES;
	localparam int NZ = DEF_MAX_ZONES;
	localparam int NL = DEF_NUM_LABELS;
	// settle time after the queues empty, with margin for the worst detection
	localparam int SETTLE = 400;

	typedef struct {
		kind_t      kind;
		logic [9:0] px, py, bw, bh;
		logic [6:0] conf;
		logic [7:0] label;
		logic [2:0] zone;
		logic [3:0] vi;
		logic       flag, closes;
	} word_t;

	typedef struct {
		logic       accepted;
		logic [2:0] reason;
		logic [10:0] cx, cy;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic cfg_wen = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [9:0] cfg_data = '0;

	detection_region_filter DUT (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	logic [6:0] thr;
	logic [9:0] min_w, min_h, box_l, box_t, box_r, box_b;
	logic [19:0] area_vtx [NV];
	int area_cnt;
	logic [19:0] excl_vtx [NZ][NV];
	int excl_cnt [NZ];
	bit zone_on [NZ];
	bit lbl_ign [NL];

	word_t pending[$];
	verdict_t verdicts[$];
	int n_fail = 0, n_results = 0, n_words = 0;
	bit rx_enable = 1'b1;

	// which vertices have been written, so no test reads undefined storage
	bit area_written [NV];
	bit excl_written [NZ][NV];

	function automatic bit point_in_poly(input logic [19:0] v [NV], input int n,
			input int px, input int py);
		bit in;
		int j, xi, yi, xj, yj, dy, lhs, rhs;
		in = 1'b0;
		if (n < 3 || n > NV) return 1'b0;
		j = n - 1;
		for (int i = 0; i < n; i++) begin
			xi = v[i][9:0]; yi = v[i][19:10];
			xj = v[j][9:0]; yj = v[j][19:10];
			if ((yi > py) != (yj > py)) begin
				dy = yj - yi;
				lhs = (px - xi) * dy;
				rhs = (xj - xi) * (py - yi);
				if (dy > 0 ? lhs < rhs : lhs > rhs) in = !in;
			end
			j = i;
		end
		return in;
	endfunction

	// apply one accepted word to the predictor state
	task automatic filter_word(input word_t w);
		verdict_t r;
		int cx, cy;
		bit in_area;
		case (w.kind)
			KIND_AREA: begin
				area_vtx[w.vi] = {w.py, w.px};
				if (w.closes) area_cnt = w.vi + 1;
			end
			KIND_EXCL: begin
				excl_vtx[w.zone][w.vi] = {w.py, w.px};
				zone_on[w.zone] = w.flag;
				if (w.closes) excl_cnt[w.zone] = w.vi + 1;
			end
			KIND_LABEL: lbl_ign[w.label] = w.flag;
			default: begin
				cx = w.px + (w.bw >> 1);
				cy = w.py + (w.bh >> 1);
				r.reason = RSN_NONE;
				if (w.conf < thr) r.reason = RSN_CONF;
				else if (w.bw < min_w || w.bh < min_h) r.reason = RSN_SIZE;
				else begin
					if (area_cnt >= 3) in_area = point_in_poly(area_vtx, area_cnt, cx, cy);
					else in_area = cx >= box_l && cx <= box_r && cy >= box_t && cy <= box_b;
					if (!in_area) r.reason = RSN_AREA;
				end
				if (r.reason == RSN_NONE)
					for (int z = 0; z < NZ; z++)
						if (zone_on[z] && point_in_poly(excl_vtx[z], excl_cnt[z], cx, cy)) begin
							r.reason = RSN_EXCL;
							break;
						end
				if (r.reason == RSN_NONE && lbl_ign[w.label]) r.reason = RSN_LABEL;
				r.accepted = (r.reason == RSN_NONE);
				r.cx = cx[10:0];
				r.cy = cy[10:0];
				verdicts.push_back(r);
			end
		endcase
	endtask

	// handshakes seen at the rising edge, used by the falling edge blocks
	bit in_taken = 1'b0;
	bit out_taken = 1'b0;
	always @(posedge clk) begin
		in_taken <= s_axis_tvalid && s_axis_tready;
		out_taken <= m_axis_tvalid && m_axis_tready;
	end

	// driver: one word at a time from the pending queue, random gaps
	int gap = 0;
	always @(negedge clk) begin
		if (in_taken) begin
			// handshake completed at the last rising edge
			filter_word(pending.pop_front());
			n_words++;
			gap = $urandom_range(0, 3);
		end
		if (pending.size() != 0 && gap == 0) begin
			s_axis_tvalid <= 1'b1;
			s_axis_tuser <= pending[0].kind;
			s_axis_tlast <= pending[0].closes;
			s_axis_tdata <= {13'd0, pending[0].flag, pending[0].vi, pending[0].zone,
				pending[0].label, pending[0].conf, pending[0].bh, pending[0].bw,
				pending[0].py, pending[0].px};
		end else begin
			s_axis_tvalid <= 1'b0;
			if (gap > 0) gap--;
		end
	end

	// result stall pattern drawn per word
	int stall = 0;
	always @(negedge clk) begin
		if (out_taken) stall = $urandom_range(0, 3);
		if (stall > 0) begin
			stall--;
			m_axis_tready <= 1'b0;
		end else
			m_axis_tready <= rx_enable;
	end

	// monitor: compare each result word with the oldest prediction
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			verdict_t e;
			n_results++;
			if (verdicts.size() == 0) begin
				$error("result word with no detection outstanding: %h", m_axis_tdata);
				n_fail++;
			end else begin
				e = verdicts.pop_front();
				if (m_axis_tdata[0] !== e.accepted) begin
					$error("accepted: expected %0d, got %0d", e.accepted, m_axis_tdata[0]);
					n_fail++;
				end
				if (m_axis_tdata[3:1] !== e.reason) begin
					$error("reject_reason: expected %0d, got %0d", e.reason, m_axis_tdata[3:1]);
					n_fail++;
				end
				if (m_axis_tdata[14:4] !== e.cx) begin
					$error("center_x: expected %0d, got %0d", e.cx, m_axis_tdata[14:4]);
					n_fail++;
				end
				if (m_axis_tdata[25:15] !== e.cy) begin
					$error("center_y: expected %0d, got %0d", e.cy, m_axis_tdata[25:15]);
					n_fail++;
				end
			end
		end
	end

	function automatic word_t blank_word(input kind_t k);
		word_t w;
		w = '{kind: k, px: 0, py: 0, bw: 0, bh: 0, conf: 0, label: 0, zone: 0,
			vi: 0, flag: 0, closes: 0};
		return w;
	endfunction

	function automatic word_t det_word(input int px, input int py, input int bw,
			input int bh, input int conf, input int label);
		word_t w;
		w = blank_word(KIND_DET);
		w.px = 10'(px); w.py = 10'(py); w.bw = 10'(bw); w.bh = 10'(bh);
		w.conf = 7'(conf); w.label = 8'(label);
		return w;
	endfunction

	function automatic word_t vtx_word(input kind_t k, input int zone, input int vi,
			input int x, input int y, input bit flag, input bit closes);
		word_t w;
		w = blank_word(k);
		w.zone = 3'(zone); w.vi = 4'(vi); w.px = 10'(x); w.py = 10'(y);
		w.flag = flag; w.closes = closes;
		return w;
	endfunction

	// random content, mostly in the normalized range, sometimes any raw value
	function automatic int coord();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 1000);
	endfunction

	// closing a polygon is only legal once every covered vertex was written
	function automatic bit closable(input kind_t k, input int zone, input int vi);
		for (int i = 0; i <= vi; i++)
			if (k == KIND_AREA ? !area_written[i] : !excl_written[zone][i]) return 1'b0;
		return 1'b1;
	endfunction

	task automatic queue_word(input word_t w);
		if (w.kind == KIND_AREA) area_written[w.vi] = 1'b1;
		if (w.kind == KIND_EXCL) excl_written[w.zone][w.vi] = 1'b1;
		pending.push_back(w);
	endtask

	// write a whole polygon of n vertices around a random center
	task automatic queue_polygon(input kind_t k, input int zone, input int n, input bit flag);
		int cx, cy, rad;
		cx = $urandom_range(150, 850);
		cy = $urandom_range(150, 850);
		rad = $urandom_range(30, 400);
		for (int i = 0; i < n; i++) begin
			int x, y, r;
			r = $urandom_range(rad / 3, rad);
			// crude star polygon; self-crossings are fine for even-odd
			case (i % 4)
				0: begin x = cx + r; y = cy - r * (i % 3) / 2; end
				1: begin x = cx - r * (i % 3) / 2; y = cy + r; end
				2: begin x = cx - r; y = cy + r * (i % 3) / 2; end
				default: begin x = cx + r * (i % 3) / 2; y = cy - r; end
			endcase
			x = (x < 0) ? 0 : (x > 1023) ? 1023 : x;
			y = (y < 0) ? 0 : (y > 1023) ? 1023 : y;
			queue_word(vtx_word(k, zone, i, x, y, flag, i == n - 1));
		end
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [9:0] val);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			CFG_CONF_THR: thr = val[6:0];
			CFG_MIN_W:    min_w = val;
			CFG_MIN_H:    min_h = val;
			CFG_AOI_L:    box_l = val;
			CFG_AOI_T:    box_t = val;
			CFG_AOI_R:    box_r = val;
			default:      box_b = val;
		endcase
	endtask

	// wait until the queue is drained and the block has settled
	task automatic drain();
		while (pending.size() != 0 || s_axis_tvalid || verdicts.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic random_phase(input int count);
		for (int i = 0; i < count; i++) begin
			int pick;
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				// detection; confidence leans toward the threshold region
				queue_word(det_word(coord(), coord(), $urandom_range(0, 9) == 0 ?
					$urandom_range(0, 1023) : $urandom_range(0, 400),
					$urandom_range(0, 9) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 400),
					$urandom_range(0, 3) == 0 ? $urandom_range(0, 127) : $urandom_range(20, 100),
					$urandom_range(0, 255)));
			end else if (pick < 76) begin
				queue_polygon(KIND_AREA, 0, $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) :
					$urandom_range(3, NV), 1'b0);
				i += 3;
			end else if (pick < 84) begin
				queue_polygon(KIND_EXCL, $urandom_range(0, NZ - 1),
					$urandom_range(0, 4) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 8),
					$urandom_range(0, 2) != 0);
				i += 3;
			end else if (pick < 92) begin
				word_t w;
				w = blank_word(KIND_LABEL);
				w.label = 8'($urandom_range(0, 255));
				w.flag = $urandom_range(0, 3) == 0;
				w.px = 10'($urandom); w.conf = 7'($urandom);
				queue_word(w);
			end else begin
				// lone vertex write, closing only where every vertex below is known
				kind_t k;
				int z, v;
				bit cl;
				k = $urandom_range(0, 1) ? KIND_AREA : KIND_EXCL;
				z = $urandom_range(0, NZ - 1);
				v = $urandom_range(0, NV - 1);
				cl = $urandom_range(0, 1) != 0;
				if (cl && !closable(k, z, v)) cl = 1'b0;
				queue_word(vtx_word(k, z, v, $urandom_range(0, 1023), $urandom_range(0, 1023),
					$urandom_range(0, 1) != 0, cl));
			end
		end
	endtask

	initial begin
		thr = RST_CONF_THR; min_w = RST_MIN_W; min_h = RST_MIN_H;
		box_l = RST_AOI_LO; box_t = RST_AOI_LO; box_r = RST_AOI_HI; box_b = RST_AOI_HI;
		area_cnt = 0;
		for (int z = 0; z < NZ; z++) begin
			excl_cnt[z] = 0;
			zone_on[z] = 1'b0;
		end
		for (int l = 0; l < NL; l++) lbl_ign[l] = 1'b0;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// directed: reset defaults, field extremes, each reason
		queue_word(det_word(500, 500, 0, 0, 50, 0));         // passes at defaults
		queue_word(det_word(500, 500, 10, 10, 49, 0));       // just below threshold
		queue_word(det_word(0, 0, 0, 0, 100, 255));          // outside fallback box
		queue_word(det_word(1023, 1023, 1023, 1023, 127, 255)); // raw maxima, wide center
		queue_word(det_word(100, 100, 0, 0, 60, 1));         // box corner inclusive
		queue_word(det_word(900, 900, 1, 1, 60, 2));         // box far corner inclusive
		queue_word(det_word(901, 500, 0, 0, 60, 2));         // just outside right
		begin
			word_t w;
			w = blank_word(KIND_LABEL);
			w.label = 7; w.flag = 1'b1;
			queue_word(w);
		end
		queue_word(det_word(400, 400, 100, 100, 80, 7));     // label ignored
		// exclude zone square, active
		queue_word(vtx_word(KIND_EXCL, 3, 0, 300, 300, 1, 0));
		queue_word(vtx_word(KIND_EXCL, 3, 1, 600, 300, 1, 0));
		queue_word(vtx_word(KIND_EXCL, 3, 2, 600, 600, 1, 0));
		queue_word(vtx_word(KIND_EXCL, 3, 3, 300, 600, 1, 1));
		queue_word(det_word(400, 400, 100, 100, 80, 0));     // excluded
		queue_word(det_word(700, 700, 10, 10, 80, 0));       // outside the zone
		// area triangle; short exclude zone that never excludes
		queue_word(vtx_word(KIND_AREA, 0, 0, 0, 0, 0, 0));
		queue_word(vtx_word(KIND_AREA, 0, 1, 1000, 0, 0, 0));
		queue_word(vtx_word(KIND_AREA, 0, 2, 0, 1000, 0, 1));
		queue_word(det_word(100, 100, 20, 20, 90, 0));       // inside triangle
		queue_word(det_word(800, 800, 20, 20, 90, 0));       // outside triangle
		queue_word(vtx_word(KIND_EXCL, 5, 1, 0, 0, 1, 0));
		queue_word(vtx_word(KIND_EXCL, 5, 0, 1023, 1023, 1, 1));
		queue_word(vtx_word(KIND_AREA, 0, 15, 1023, 1023, 1, 0)); // top vertex index, open
		queue_word(det_word(200, 200, 0, 0, 90, 0));
		drain();

		// size limits and an inverted fallback box (back to short area polygon)
		write_reg(CFG_MIN_W, 10'd1000);
		write_reg(CFG_MIN_H, 10'd1000);
		queue_word(det_word(0, 0, 999, 1000, 100, 0));
		queue_word(det_word(0, 0, 1000, 1000, 100, 0));
		queue_word(vtx_word(KIND_AREA, 0, 1, 5, 5, 0, 1));   // area count two
		drain();
		write_reg(CFG_MIN_W, 10'd0);
		write_reg(CFG_MIN_H, 10'd0);
		write_reg(CFG_AOI_L, 10'd800);
		write_reg(CFG_AOI_R, 10'd200);
		write_reg(CFG_CONF_THR, 10'd0);
		queue_word(det_word(500, 500, 0, 0, 0, 0));
		random_phase(150);
		drain();

		// several settings, extremes among them
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(CFG_CONF_THR, ph == 0 ? 10'd100 : ph == 1 ? 10'd127 :
				10'($urandom_range(0, 100)));
			write_reg(CFG_MIN_W, ph == 2 ? 10'd1023 : 10'($urandom_range(0, 60)));
			write_reg(CFG_MIN_H, ph == 3 ? 10'd1023 : 10'($urandom_range(0, 60)));
			write_reg(CFG_AOI_L, ph == 4 ? 10'd0 : 10'($urandom_range(0, 400)));
			write_reg(CFG_AOI_T, ph == 4 ? 10'd0 : 10'($urandom_range(0, 400)));
			write_reg(CFG_AOI_R, ph == 4 ? 10'd1023 : 10'($urandom_range(500, 1023)));
			write_reg(CFG_AOI_B, ph == 4 ? 10'd1023 : 10'($urandom_range(500, 1023)));
			random_phase(130);
			drain();
		end
		write_reg(CFG_CONF_THR, 10'd30);
		random_phase(80);
		drain();

		$display("words accepted: %0d, detection results checked: %0d", n_words, n_results);
		$display("covered all word kinds, every reject reason and %0d register settings", 9);
		if (n_fail == 0)
			$display("** detection_region_filter: PASSED **");
		else
			$display("** detection_region_filter: FAILED **");
		$finish;
	end

	initial begin
		#20ms;
		$display("** detection_region_filter: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire
